// ===== hw/rtl/fep_pkg.sv =====
package fep_pkg;

  // Default sizes of the coefficient table and of the angle iteration.
  localparam int MAX_TERMS_DEF    = 32;
  localparam int CORDIC_STEPS_DEF = 18;

  // Fixed widths of the fields and of the internal arithmetic.
  localparam int RAY_W   = 19;
  localparam int PIX_W   = 24;
  localparam int CTR_W   = 21;
  localparam int AFF_W   = 18;
  localparam int COEF_W  = 32;
  localparam int RHO_W   = 40;
  localparam int THETA_W = 23;
  localparam int NRM_W   = 27;
  localparam int RAD_W   = 54;
  localparam int XS_W    = 38;
  localparam int DIV_W   = 62;
  localparam int MUL_AW  = 41;
  localparam int MUL_BW  = 24;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_CENTER_ROW = 3'd0,
    REG_CENTER_COL = 3'd1,
    REG_AFFINE_C   = 3'd2,
    REG_AFFINE_D   = 3'd3,
    REG_AFFINE_E   = 3'd4,
    REG_POLY_TERMS = 3'd5,
    REG_COEF_INDEX = 3'd6,
    REG_COEF_VALUE = 3'd7
  } reg_idx_t;

  // atan(2^-i) in Q2.30, zero past the end of the table.
  function automatic logic [31:0] atan_q30(input logic [5:0] i);
    logic [31:0] v;
    case (i)
      6'd0:  v = 32'd843314857;
      6'd1:  v = 32'd497837829;
      6'd2:  v = 32'd263043837;
      6'd3:  v = 32'd133525159;
      6'd4:  v = 32'd67021687;
      6'd5:  v = 32'd33543516;
      6'd6:  v = 32'd16775851;
      6'd7:  v = 32'd8388437;
      6'd8:  v = 32'd4194283;
      6'd9:  v = 32'd2097149;
      6'd10: v = 32'd1048576;
      6'd11: v = 32'd524288;
      6'd12: v = 32'd262144;
      6'd13: v = 32'd131072;
      6'd14: v = 32'd65536;
      6'd15: v = 32'd32768;
      6'd16: v = 32'd16384;
      6'd17: v = 32'd8192;
      6'd18: v = 32'd4096;
      6'd19: v = 32'd2048;
      6'd20: v = 32'd1024;
      6'd21: v = 32'd512;
      6'd22: v = 32'd256;
      6'd23: v = 32'd128;
      6'd24: v = 32'd64;
      6'd25: v = 32'd32;
      6'd26: v = 32'd16;
      6'd27: v = 32'd8;
      6'd28: v = 32'd4;
      6'd29: v = 32'd2;
      6'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/fep_mul.sv =====
// Shared signed multiplier with a registered product.
module fep_mul import fep_pkg::*; #(
  parameter int AW = MUL_AW,
  parameter int BW = MUL_BW
) (
  input  logic                      clk,
  input  logic signed [AW-1:0]      a,
  input  logic signed [BW-1:0]      b,
  output logic signed [AW+BW-1:0]   p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ===== hw/rtl/fisheye_ray_to_pixel_projection_top.sv =====
// Fisheye ray to pixel projection.
//
// A request on the input stream carries one ray (x, y, z) in Q2.16. The block
// forms the radial norm with a bit-serial square root, the elevation angle
// with CORDIC vectoring, the image radius rho with a Horner loop over the
// coefficient table, scales x and y by rho/norm with a restoring divider and
// applies the sensor matrix plus image centre. One result request leaves on
// the output stream for every input request.
// All products go through one shared multiplier; the square root, the CORDIC
// and the divider are one-step-per-cycle loops. An on-axis ray (x and y both
// zero) skips the loops and goes straight to the output. The input is not
// ready while an item is in work.
// The result sits in an output register; the next item is accepted while it
// waits, and a new result waits in its own state until the receiver takes it.
// Reset clears the registers to their defaults and the coefficient table to
// zero through per-entry valid bits, so the block is usable right after reset.
// Configuration writes belong in idle periods.
module fisheye_ray_to_pixel_projection_top import fep_pkg::*; #(
  parameter int MAX_TERMS    = MAX_TERMS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // ray_x [18:0], ray_y [37:19], ray_z [56:38]
  input  logic [63:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pixel_row [23:0], pixel_col [47:24]
  output logic [47:0] out_tdata,
  // on_axis [0], clipped [1]
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CIW   = $clog2(MAX_TERMS);
  localparam int TW    = $clog2(MAX_TERMS + 1);
  localparam int CNT_W = $clog2(DIV_W + MAX_TERMS + CORDIC_STEPS + NRM_W);

  typedef enum logic [20:0] {
    ST_IDLE  = 21'h000001,
    ST_SQX   = 21'h000002,
    ST_SQY   = 21'h000004,
    ST_SQS   = 21'h000008,
    ST_SQRT  = 21'h000010,
    ST_CORD  = 21'h000020,
    ST_HLD   = 21'h000040,
    ST_HINIT = 21'h000080,
    ST_HMUL  = 21'h000100,
    ST_HACC  = 21'h000200,
    ST_PM    = 21'h000400,
    ST_PW    = 21'h000800,
    ST_PD    = 21'h001000,
    ST_DIV   = 21'h002000,
    ST_PEND  = 21'h004000,
    ST_A1    = 21'h008000,
    ST_A2    = 21'h010000,
    ST_A3    = 21'h020000,
    ST_A4    = 21'h040000,
    ST_A5    = 21'h080000,
    ST_OUT   = 21'h100000
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers and coefficient table.
  // ---------------------------------------------------------------------------
  logic [CTR_W-1:0]        center_row_r, center_col_r;
  logic signed [AFF_W-1:0] affine_c_r, affine_d_r, affine_e_r;
  logic [5:0]              poly_terms_r;
  logic [4:0]              coef_index_r;
  logic signed [COEF_W-1:0] coef_value_r;

  logic signed [COEF_W-1:0] coef_mem [MAX_TERMS];
  logic [MAX_TERMS-1:0]     coef_vld_r;
  logic signed [COEF_W-1:0] coef_rd_r;
  logic                     coef_rd_vld_r;
  logic                     coef_wr;

  assign coef_wr = cfg_we && (reg_idx_t'(cfg_index) == REG_COEF_VALUE) &&
                   (32'(coef_index_r) < 32'(MAX_TERMS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_row_r <= '0;
      center_col_r <= '0;
      affine_c_r   <= AFF_W'(65536);
      affine_d_r   <= '0;
      affine_e_r   <= '0;
      poly_terms_r <= 6'd1;
      coef_index_r <= '0;
      coef_value_r <= '0;
      coef_vld_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_CENTER_ROW: center_row_r <= cfg_data[CTR_W-1:0];
          REG_CENTER_COL: center_col_r <= cfg_data[CTR_W-1:0];
          REG_AFFINE_C:   affine_c_r   <= cfg_data[AFF_W-1:0];
          REG_AFFINE_D:   affine_d_r   <= cfg_data[AFF_W-1:0];
          REG_AFFINE_E:   affine_e_r   <= cfg_data[AFF_W-1:0];
          REG_POLY_TERMS: poly_terms_r <= cfg_data[5:0];
          REG_COEF_INDEX: coef_index_r <= cfg_data[4:0];
          REG_COEF_VALUE: coef_value_r <= cfg_data;
          default: ;
        endcase
      end
      if (coef_wr) begin
        coef_vld_r[CIW'(coef_index_r)] <= 1'b1;
      end
    end
  end

  // The table holds the last value written, which is also what coef_value_r
  // shows after the write.
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[CIW'(coef_index_r)] <= signed'(cfg_data);
    end
    coef_rd_r     <= coef_mem[cnt_r[CIW-1:0]];
    coef_rd_vld_r <= coef_vld_r[cnt_r[CIW-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier.
  // ---------------------------------------------------------------------------
  logic signed [MUL_AW-1:0]        mul_a;
  logic signed [MUL_BW-1:0]        mul_b;
  logic signed [MUL_AW+MUL_BW-1:0] mul_p;

  fep_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // ---------------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic signed [RAY_W-1:0]   x_r, y_r, z_r;
  logic [37:0]               sum_r;
  logic [RAD_W-1:0]          rad_r;
  logic [29:0]               srem_r;
  logic [NRM_W-1:0]          nrm_r;
  logic signed [30:0]        cx_r, cy_r;
  logic signed [32:0]        ang_r;
  logic signed [THETA_W-1:0] theta_r;
  logic signed [RHO_W-1:0]   rho_r;
  logic [DIV_W-1:0]          q_r;
  logic [NRM_W:0]            drem_r;
  logic                      neg_r, sel_y_r, clip_r;
  logic signed [XS_W-1:0]    xs_r, ys_r;
  logic signed [57:0]        accr_r, accc_r;
  logic signed [PIX_W-1:0]   res_row_r, res_col_r;
  logic                      res_on_r;

  logic [PIX_W-1:0]          out_row_r, out_col_r;
  logic                      out_on_r, out_clip_r, out_tvalid_r;

  // Square root step: bring down two radicand bits, try root*4+1.
  logic [29:0]      sq_rem2, sq_trial;
  logic             sq_ge;
  logic [NRM_W-1:0] sq_root;

  assign sq_rem2  = {srem_r[27:0], rad_r[RAD_W-1 -: 2]};
  assign sq_trial = {1'b0, nrm_r, 2'b01};
  assign sq_ge    = sq_rem2 >= sq_trial;
  assign sq_root  = {nrm_r[NRM_W-2:0], sq_ge};

  // CORDIC vectoring step.
  logic signed [30:0] cd_dx, cd_dy, cd_cx, cd_cy;
  logic signed [32:0] cd_a, cd_ang, cd_t;

  assign cd_dx  = cy_r >>> cnt_r;
  assign cd_dy  = cx_r >>> cnt_r;
  assign cd_a   = signed'({1'b0, atan_q30(6'(cnt_r))});
  assign cd_cx  = cy_r[30] ? cx_r - cd_dx : cx_r + cd_dx;
  assign cd_cy  = cy_r[30] ? cy_r + cd_dy : cy_r - cd_dy;
  assign cd_ang = cy_r[30] ? ang_r - cd_a : ang_r + cd_a;
  assign cd_t   = cd_ang + 33'sd512;

  // Number of terms in use, clamped to the table.
  logic [TW-1:0] nterm;

  always_comb begin
    if (poly_terms_r == 6'd0) begin
      nterm = TW'(1);
    end else if (32'(poly_terms_r) > 32'(MAX_TERMS)) begin
      nterm = TW'(MAX_TERMS);
    end else begin
      nterm = TW'(poly_terms_r);
    end
  end

  // Horner accumulate: round the product down by 2^20, add the next coefficient
  // and saturate to the rho range.
  logic signed [64:0]        h_t;
  logic signed [44:0]        h_s;
  logic signed [COEF_W-1:0]  h_coef;
  logic signed [45:0]        h_sum;
  logic signed [RHO_W-1:0]   h_rho;
  logic                      h_clip;

  assign h_t    = mul_p + 65'sd524288;
  assign h_s    = h_t[64:20];
  assign h_coef = coef_rd_vld_r ? coef_rd_r : '0;
  assign h_sum  = 46'(h_s) + 46'(h_coef);

  always_comb begin
    h_clip = 1'b1;
    if (h_sum > 46'sd549755813887) begin
      h_rho = {1'b0, {(RHO_W-1){1'b1}}};
    end else if (h_sum < -46'sd549755813888) begin
      h_rho = {1'b1, {(RHO_W-1){1'b0}}};
    end else begin
      h_rho  = h_sum[RHO_W-1:0];
      h_clip = 1'b0;
    end
  end

  // Division set-up: magnitude of x*rho*16 (or y*rho*16) plus half the norm.
  logic [64:0]      pd_mag;
  logic [DIV_W-1:0] pd_num;

  assign pd_mag = mul_p[64] ? 65'(-mul_p) : 65'(mul_p);
  assign pd_num = {pd_mag[DIV_W-5:0], 4'b0000} + DIV_W'(nrm_r >> 1);

  // Restoring division step.
  logic [NRM_W:0] dv_rem2;
  logic           dv_ge;

  assign dv_rem2 = {drem_r[NRM_W-1:0], q_r[DIV_W-1]};
  assign dv_ge   = dv_rem2 >= {1'b0, nrm_r};

  logic signed [XS_W-1:0] pe_q;

  assign pe_q = neg_r ? -signed'(q_r[XS_W-1:0]) : signed'(q_r[XS_W-1:0]);

  // Final rounding, centre offset and saturation to the pixel range.
  logic signed [57:0] fr_t, fc_t;
  logic signed [38:0] fr_v, fc_v;
  logic signed [PIX_W-1:0] fr_sat, fc_sat;
  logic               fr_clip, fc_clip;

  assign fr_t = accr_r + 58'sd524288;
  assign fc_t = accc_r + 58'sd524288;
  assign fr_v = 39'(signed'(fr_t[57:20])) + 39'(signed'({1'b0, center_row_r}));
  assign fc_v = 39'(signed'(fc_t[57:20])) + 39'(signed'({1'b0, center_col_r}));

  always_comb begin
    fr_clip = 1'b1;
    fc_clip = 1'b1;
    if (fr_v > 39'sd8388607) begin
      fr_sat = {1'b0, {(PIX_W-1){1'b1}}};
    end else if (fr_v < -39'sd8388608) begin
      fr_sat = {1'b1, {(PIX_W-1){1'b0}}};
    end else begin
      fr_sat  = fr_v[PIX_W-1:0];
      fr_clip = 1'b0;
    end
    if (fc_v > 39'sd8388607) begin
      fc_sat = {1'b0, {(PIX_W-1){1'b1}}};
    end else if (fc_v < -39'sd8388608) begin
      fc_sat = {1'b1, {(PIX_W-1){1'b0}}};
    end else begin
      fc_sat  = fc_v[PIX_W-1:0];
      fc_clip = 1'b0;
    end
  end

  logic in_acc, out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // ---------------------------------------------------------------------------
  // Multiplier operand selection.
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQX: begin
        mul_a = MUL_AW'(x_r);
        mul_b = MUL_BW'(x_r);
      end
      ST_SQY: begin
        mul_a = MUL_AW'(y_r);
        mul_b = MUL_BW'(y_r);
      end
      ST_HMUL: begin
        mul_a = MUL_AW'(rho_r);
        mul_b = MUL_BW'(theta_r);
      end
      // The operands stay put for the wait cycle so that the product is
      // still there when the divider is loaded.
      ST_PM, ST_PW: begin
        mul_a = MUL_AW'(rho_r);
        mul_b = sel_y_r ? MUL_BW'(y_r) : MUL_BW'(x_r);
      end
      ST_A1: begin
        mul_a = MUL_AW'(xs_r);
        mul_b = MUL_BW'(affine_c_r);
      end
      ST_A2: begin
        mul_a = MUL_AW'(ys_r);
        mul_b = MUL_BW'(affine_d_r);
      end
      ST_A3: begin
        mul_a = MUL_AW'(xs_r);
        mul_b = MUL_BW'(affine_e_r);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tdata[RAY_W-1:0] == '0 && in_tdata[2*RAY_W-1:RAY_W] == '0) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_SQX;
          end
        end
      end
      ST_SQX: state_nxt = ST_SQY;
      ST_SQY: state_nxt = ST_SQS;
      ST_SQS: begin
        state_nxt = ST_SQRT;
        cnt_nxt   = '0;
      end
      ST_SQRT: begin
        if (cnt_r == CNT_W'(NRM_W - 1)) begin
          state_nxt = ST_CORD;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CORD: begin
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_HLD;
          cnt_nxt   = CNT_W'(nterm - 1'b1);
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_HLD: state_nxt = ST_HINIT;
      ST_HINIT: begin
        if (cnt_r == '0) begin
          state_nxt = ST_PM;
        end else begin
          state_nxt = ST_HMUL;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      ST_HMUL: state_nxt = ST_HACC;
      ST_HACC: begin
        if (cnt_r == '0) begin
          state_nxt = ST_PM;
        end else begin
          state_nxt = ST_HMUL;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      ST_PM: state_nxt = ST_PW;
      ST_PW: state_nxt = ST_PD;
      ST_PD: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          state_nxt = ST_PEND;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_PEND: state_nxt = sel_y_r ? ST_A1 : ST_PM;
      ST_A1:   state_nxt = ST_A2;
      ST_A2:   state_nxt = ST_A3;
      ST_A3:   state_nxt = ST_A4;
      ST_A4:   state_nxt = ST_A5;
      ST_A5:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        x_r      <= in_tdata[RAY_W-1:0];
        y_r      <= in_tdata[2*RAY_W-1:RAY_W];
        z_r      <= in_tdata[3*RAY_W-1:2*RAY_W];
        clip_r   <= 1'b0;
        sel_y_r  <= 1'b0;
        res_on_r <= 1'b1;
        res_row_r <= PIX_W'(center_row_r);
        res_col_r <= PIX_W'(center_col_r);
      end
      ST_SQY: begin
        sum_r    <= mul_p[37:0];
        res_on_r <= 1'b0;
      end
      ST_SQS: begin
        rad_r  <= {sum_r + mul_p[37:0], 16'b0};
        srem_r <= '0;
        nrm_r  <= '0;
      end
      ST_SQRT: begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        srem_r <= sq_ge ? sq_rem2 - sq_trial : sq_rem2;
        nrm_r  <= sq_root;
        if (cnt_r == CNT_W'(NRM_W - 1)) begin
          cx_r  <= 31'(sq_root);
          cy_r  <= signed'({{4{z_r[RAY_W-1]}}, z_r, 8'b0});
          ang_r <= '0;
        end
      end
      ST_CORD: begin
        cx_r    <= cd_cx;
        cy_r    <= cd_cy;
        ang_r   <= cd_ang;
        theta_r <= cd_t[32:10];
      end
      ST_HINIT: begin
        rho_r <= RHO_W'(h_coef);
      end
      ST_HACC: begin
        rho_r <= h_rho;
        if (h_clip) begin
          clip_r <= 1'b1;
        end
      end
      ST_PD: begin
        q_r    <= pd_num;
        drem_r <= '0;
        neg_r  <= mul_p[64];
      end
      ST_DIV: begin
        q_r    <= {q_r[DIV_W-2:0], dv_ge};
        drem_r <= dv_ge ? dv_rem2 - {1'b0, nrm_r} : dv_rem2;
      end
      ST_PEND: begin
        if (sel_y_r) begin
          ys_r <= pe_q;
        end else begin
          xs_r <= pe_q;
        end
        sel_y_r <= 1'b1;
      end
      ST_A2: accr_r <= 58'(mul_p);
      ST_A3: accr_r <= accr_r + 58'(mul_p);
      ST_A4: accc_r <= 58'(mul_p) + (58'(ys_r) <<< 16);
      ST_A5: begin
        res_row_r <= fr_sat;
        res_col_r <= fc_sat;
        if (fr_clip || fc_clip) begin
          clip_r <= 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_row_r  <= res_row_r;
          out_col_r  <= res_col_r;
          out_on_r   <= res_on_r;
          out_clip_r <= clip_r && !res_on_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_col_r, out_row_r};
  assign out_tuser  = {out_clip_r, out_on_r};

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != ST_IDLE)
    else $error("block still idle after accepting a ray");

  a_axis_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_on_r && out_clip_r))
    else $error("on-axis result flagged as clipped");

  a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PD |-> nrm_r != '0)
    else $error("division by a zero norm");

  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CORD |-> cnt_r < CNT_W'(CORDIC_STEPS))
    else $error("CORDIC step count out of range");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r < CNT_W'(DIV_W))
    else $error("division step count out of range");

endmodule
